// ===== src/cddu_pkg.sv =====
`default_nettype none

package cddu_pkg;

   localparam int AMOUNT_FIELD_W = 16;
   localparam int YEAR_W         = 14;
   localparam int MONTH_W        = 4;
   localparam int DAY_W          = 5;

   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_DAYS   = 2'd1,
      ACT_MONTHS = 2'd2,
      ACT_YEARS  = 2'd3
   } action_type;

   typedef struct packed {
      action_type                  action;
      logic [AMOUNT_FIELD_W-1:0]   amount;
      logic [YEAR_W-1:0]           set_year;
      logic [MONTH_W-1:0]          set_month;
      logic [DAY_W-1:0]            set_day;
   } req_payload_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  out_year;
      logic [MONTH_W-1:0] out_month;
      logic [DAY_W-1:0]   out_day;
      logic               underflow;
   } rsp_payload_type;

   typedef struct packed {
      logic start;
      logic step_day;
      logic step_month;
      logic clamp;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic underflow;
   } status_type;

   localparam logic [YEAR_W-1:0]  RESET_YEAR    = 14'd2000;
   localparam logic [YEAR_W-1:0]  YEAR_MAX      = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FIRST     = 5'd1;
   localparam logic [DAY_W-1:0]   DAY_DEC_LAST  = 5'd31;
   localparam logic [DAY_W-1:0]   DAY_LONGEST   = 5'd31;
   localparam logic [DAY_W-1:0]   DAYS_FEB_LEAP = 5'd29;

   localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // n is a multiple of 25 iff (n * 25^-1 mod 2^14) <= floor((2^14-1)/25)
   localparam logic [YEAR_W-1:0] INV25       = 14'd7209;
   localparam logic [YEAR_W-1:0] DIV25_LIMIT = 14'd655;

   // 100 = 4*25 and 400 = 16*25
   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      logic [YEAR_W-1:0] scaled;
      logic              div25;
      scaled = YEAR_W'(year * INV25);
      div25  = (scaled <= DIV25_LIMIT);
      return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                   input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] len;
      len = DAY_LONGEST;
      if (month >= MONTH_JAN && month <= MONTH_DEC) begin
         len = MONTH_LEN[month - MONTH_JAN];
      end
      if (month == MONTH_FEB && leap) begin
         len = DAYS_FEB_LEAP;
      end
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== src/cddu_stream_if.sv =====
`default_nettype none

interface cddu_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/calendar_date_decrement_unit.sv =====
`default_nettype none

// channel    dir  modport  payload
// req_chan   in   sink     action, amount, set_year, set_month, set_day
// rsp_chan   out  source   out_year, out_month, out_day, underflow
//
// Load and year subtract pass through the clamp and finish states to the result register.
// Day and month subtract: the day/month step loop advances one unit per cycle
// and ends early on underflow; the finish state then loads the result register.
// Synchronous reset sets the date to 2000-01-01 and empties the output.
// A new beat is taken while a result still waits in the output register.

module calendar_date_decrement_unit #(
   parameter int AMOUNT_WIDTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   cddu_stream_if.sink   req_chan,
   cddu_stream_if.source rsp_chan
);

   cddu_pkg::cmd_type         cmd;
   cddu_pkg::status_type      status;
   cddu_pkg::req_payload_type req_payload;
   cddu_pkg::rsp_payload_type rsp_payload;
   logic                      req_ready;
   logic                      rsp_valid;

   assign req_payload = req_chan.payload;

   cddu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_payload.action),
      .req_ready  (req_ready),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_valid),
      .status     (status),
      .cmd        (cmd)
   );

   cddu_dpath #(
      .AMOUNT_WIDTH (AMOUNT_WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_payload;

endmodule

`default_nettype wire

// ===== src/cddu_dpath.sv =====
`default_nettype none

module cddu_dpath #(
   parameter int AMOUNT_WIDTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cddu_pkg::req_payload_type req_payload,
   input  wire cddu_pkg::cmd_type         cmd,
   output cddu_pkg::status_type           status,
   output cddu_pkg::rsp_payload_type      rsp_payload
);

   localparam int CNT_W = (AMOUNT_WIDTH < cddu_pkg::AMOUNT_FIELD_W) ?
                          AMOUNT_WIDTH : cddu_pkg::AMOUNT_FIELD_W;

   logic [cddu_pkg::YEAR_W-1:0]  year_ff,  year_in;
   logic [cddu_pkg::MONTH_W-1:0] month_ff, month_in;
   logic [cddu_pkg::DAY_W-1:0]   day_ff,   day_in;
   logic [CNT_W-1:0]             cnt_ff,   cnt_in;
   logic                         uf_ff,    uf_in;
   cddu_pkg::rsp_payload_type    out_ff,   out_in;

   logic                                leap;
   logic [cddu_pkg::DAY_W-1:0]          prev_len;
   logic [cddu_pkg::DAY_W-1:0]          cur_len;
   logic [cddu_pkg::AMOUNT_FIELD_W-1:0] amt_ext;
   logic [cddu_pkg::AMOUNT_FIELD_W-1:0] year_ext;

   always_comb begin
      leap     = cddu_pkg::is_leap(year_ff);
      prev_len = cddu_pkg::month_days(leap, month_ff - cddu_pkg::MONTH_JAN);
      cur_len  = cddu_pkg::month_days(leap, month_ff);
      amt_ext  = cddu_pkg::AMOUNT_FIELD_W'(req_payload.amount[CNT_W-1:0]);
      year_ext = cddu_pkg::AMOUNT_FIELD_W'(year_ff);
   end

   always_comb begin
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      cnt_in   = cnt_ff;
      uf_in    = uf_ff;
      out_in   = out_ff;

      if (cmd.start) begin
         uf_in  = 1'b0;
         cnt_in = req_payload.amount[CNT_W-1:0];
         case (req_payload.action)
            cddu_pkg::ACT_LOAD: begin
               // saturate out-of-range fields; day fixed up in the clamp cycle
               year_in  = (req_payload.set_year > cddu_pkg::YEAR_MAX) ?
                          cddu_pkg::YEAR_MAX : req_payload.set_year;
               month_in = req_payload.set_month;
               if (req_payload.set_month < cddu_pkg::MONTH_JAN) begin
                  month_in = cddu_pkg::MONTH_JAN;
               end else if (req_payload.set_month > cddu_pkg::MONTH_DEC) begin
                  month_in = cddu_pkg::MONTH_DEC;
               end
               day_in   = (req_payload.set_day < cddu_pkg::DAY_FIRST) ?
                          cddu_pkg::DAY_FIRST : req_payload.set_day;
            end
            cddu_pkg::ACT_YEARS: begin
               if (amt_ext > year_ext) begin
                  year_in  = '0;
                  month_in = cddu_pkg::MONTH_JAN;
                  day_in   = cddu_pkg::DAY_FIRST;
                  uf_in    = 1'b1;
               end else begin
                  year_in  = cddu_pkg::YEAR_W'(year_ext - amt_ext);
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.step_day) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (day_ff > cddu_pkg::DAY_FIRST) begin
            day_in = day_ff - cddu_pkg::DAY_W'(1);
         end else if (month_ff > cddu_pkg::MONTH_JAN) begin
            month_in = month_ff - cddu_pkg::MONTH_W'(1);
            day_in   = prev_len;
         end else if (year_ff != '0) begin
            year_in  = year_ff - cddu_pkg::YEAR_W'(1);
            month_in = cddu_pkg::MONTH_DEC;
            day_in   = cddu_pkg::DAY_DEC_LAST;
         end else begin
            uf_in    = 1'b1;
         end
      end

      if (cmd.step_month) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (month_ff > cddu_pkg::MONTH_JAN) begin
            month_in = month_ff - cddu_pkg::MONTH_W'(1);
            day_in   = (day_ff > prev_len) ? prev_len : day_ff;
         end else if (year_ff != '0) begin
            // December is 31 days, no clamp needed
            year_in  = year_ff - cddu_pkg::YEAR_W'(1);
            month_in = cddu_pkg::MONTH_DEC;
         end else begin
            day_in   = cddu_pkg::DAY_FIRST;
            uf_in    = 1'b1;
         end
      end

      if (cmd.clamp && (day_ff > cur_len)) begin
         day_in = cur_len;
      end

      if (cmd.out_load) begin
         out_in.out_year  = year_ff;
         out_in.out_month = month_ff;
         out_in.out_day   = day_ff;
         out_in.underflow = uf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff  <= cddu_pkg::RESET_YEAR;
         month_ff <= cddu_pkg::MONTH_JAN;
         day_ff   <= cddu_pkg::DAY_FIRST;
      end else begin
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      uf_ff  <= uf_in;
      out_ff <= out_in;
   end

   assign status.cnt_zero  = (cnt_ff == '0);
   assign status.underflow = uf_ff;
   assign rsp_payload      = out_ff;

`ifndef SYNTHESIS
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      month_ff >= cddu_pkg::MONTH_JAN && month_ff <= cddu_pkg::MONTH_DEC)
      else $error("month register out of range");

   a_day_nonzero: assert property (@(posedge clock) disable iff (reset)
      day_ff != '0)
      else $error("day register is zero");

   a_clamp_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.clamp |=> day_ff <= $past(cur_len))
      else $error("clamp left day past month end");
`endif

endmodule

`default_nettype wire

// ===== src/cddu_ctrl.sv =====
`default_nettype none

module cddu_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire cddu_pkg::action_type req_action,
   output logic                      req_ready,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   input  wire cddu_pkg::status_type status,
   output cddu_pkg::cmd_type         cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DAYS   = 5'b00010,
      ST_MONTHS = 5'b00100,
      ST_CLAMP  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               case (req_action)
                  cddu_pkg::ACT_DAYS:   state_in = ST_DAYS;
                  cddu_pkg::ACT_MONTHS: state_in = ST_MONTHS;
                  default:              state_in = ST_CLAMP;
               endcase
            end
         end
         ST_DAYS: begin
            if (status.cnt_zero || status.underflow) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step_day = 1'b1;
            end
         end
         ST_MONTHS: begin
            if (status.cnt_zero || status.underflow) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step_month = 1'b1;
            end
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != ST_IDLE)
      else $error("accepted beat did not start work");

   a_uf_stops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DAYS || state_ff == ST_MONTHS) && status.underflow
      |=> state_ff == ST_FINISH)
      else $error("stepping continued after underflow");

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_valid_ff || rsp_ready)
      else $error("result overwrote a pending beat");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_OPS  = 650;
   localparam int QUIET_LIMIT = 200000;
   localparam int IDLE_PCT    = 29;

   typedef struct packed {
      cddu_pkg::action_type      act;
      logic [15:0]               amount;
      logic [13:0]               year;
      logic [3:0]                month;
      logic [4:0]                day;
      logic                      known;
      cddu_pkg::rsp_payload_type date;
   } dir_row_type;

   typedef struct {
      bit                        known;
      cddu_pkg::rsp_payload_type date;
   } pinned_type;

   // known rows carry the date typed in; the others are left to the predictor
   localparam dir_row_type DIRECTED_ROWS [26] = '{
      '{cddu_pkg::ACT_DAYS,   16'd0,    14'd0,    4'd0,  5'd0,
        1'b1, '{14'd2000, 4'd1,  5'd1,  1'b0}},
      '{cddu_pkg::ACT_DAYS,   16'd1,    14'h3fff, 4'hf,  5'h1f,
        1'b1, '{14'd1999, 4'd12, 5'd31, 1'b0}},
      '{cddu_pkg::ACT_LOAD,   16'd0,    14'd2000, 4'd2,  5'd29,
        1'b1, '{14'd2000, 4'd2,  5'd29, 1'b0}},
      '{cddu_pkg::ACT_YEARS,  16'd1,    14'd0,    4'd0,  5'd0,
        1'b1, '{14'd1999, 4'd2,  5'd28, 1'b0}},
      '{cddu_pkg::ACT_LOAD,   16'd0,    14'd1900, 4'd3,  5'd1,
        1'b1, '{14'd1900, 4'd3,  5'd1,  1'b0}},
      '{cddu_pkg::ACT_DAYS,   16'd1,    14'd0,    4'd0,  5'd0,
        1'b0, '0},
      '{cddu_pkg::ACT_LOAD,   16'd0,    14'd2400, 4'd3,  5'd31,
        1'b1, '{14'd2400, 4'd3,  5'd31, 1'b0}},
      '{cddu_pkg::ACT_MONTHS, 16'd1,    14'd0,    4'd0,  5'd0,
        1'b0, '0},
      '{cddu_pkg::ACT_LOAD,   16'd0,    14'd2001, 4'd3,  5'd31,
        1'b1, '{14'd2001, 4'd3,  5'd31, 1'b0}},
      '{cddu_pkg::ACT_MONTHS, 16'd2,    14'd0,    4'd0,  5'd0,
        1'b0, '0},
      '{cddu_pkg::ACT_LOAD,   16'd0,    14'h3fff, 4'hf,  5'h1f,
        1'b1, '{14'd9999, 4'd12, 5'd31, 1'b0}},
      '{cddu_pkg::ACT_LOAD,   16'hffff, 14'd0,    4'd0,  5'd0,
        1'b1, '{14'd0,    4'd1,  5'd1,  1'b0}},
      '{cddu_pkg::ACT_DAYS,   16'd1,    14'd0,    4'd0,  5'd0,
        1'b1, '{14'd0,    4'd1,  5'd1,  1'b1}},
      '{cddu_pkg::ACT_MONTHS, 16'd1,    14'd0,    4'd0,  5'd0,
        1'b1, '{14'd0,    4'd1,  5'd1,  1'b1}},
      '{cddu_pkg::ACT_YEARS,  16'd1,    14'd0,    4'd0,  5'd0,
        1'b1, '{14'd0,    4'd1,  5'd1,  1'b1}},
      '{cddu_pkg::ACT_LOAD,   16'd0,    14'd0,    4'd3,  5'd15,
        1'b1, '{14'd0,    4'd3,  5'd15, 1'b0}},
      '{cddu_pkg::ACT_YEARS,  16'd0,    14'd0,    4'd0,  5'd0,
        1'b1, '{14'd0,    4'd3,  5'd15, 1'b0}},
      '{cddu_pkg::ACT_LOAD,   16'd0,    14'd2023, 4'd2,  5'd31,
        1'b1, '{14'd2023, 4'd2,  5'd28, 1'b0}},
      '{cddu_pkg::ACT_LOAD,   16'hffff, 14'd9999, 4'd12, 5'd31,
        1'b1, '{14'd9999, 4'd12, 5'd31, 1'b0}},
      '{cddu_pkg::ACT_DAYS,   16'hffff, 14'd0,    4'd0,  5'd0,
        1'b0, '0},
      '{cddu_pkg::ACT_MONTHS, 16'hffff, 14'd0,    4'd0,  5'd0,
        1'b0, '0},
      '{cddu_pkg::ACT_YEARS,  16'hffff, 14'd0,    4'd0,  5'd0,
        1'b1, '{14'd0,    4'd1,  5'd1,  1'b1}},
      '{cddu_pkg::ACT_LOAD,   16'd0,    14'd5,    4'd6,  5'd7,
        1'b1, '{14'd5,    4'd6,  5'd7,  1'b0}},
      '{cddu_pkg::ACT_DAYS,   16'hffff, 14'd0,    4'd0,  5'd0,
        1'b1, '{14'd0,    4'd1,  5'd1,  1'b1}},
      '{cddu_pkg::ACT_LOAD,   16'd0,    14'd9999, 4'd12, 5'd31,
        1'b1, '{14'd9999, 4'd12, 5'd31, 1'b0}},
      '{cddu_pkg::ACT_YEARS,  16'd9999, 14'd0,    4'd0,  5'd0,
        1'b1, '{14'd0,    4'd12, 5'd31, 1'b0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   cddu_stream_if #(.payload_type(cddu_pkg::req_payload_type)) req_if ();
   cddu_stream_if #(.payload_type(cddu_pkg::rsp_payload_type)) rsp_if ();

   calendar_date_decrement_unit #(.AMOUNT_WIDTH(cddu_pkg::AMOUNT_FIELD_W)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   always #5 clock = ~clock;

   // predicted calendar state
   int unsigned cal_year  = 2000;
   int unsigned cal_month = 1;
   int unsigned cal_day   = 1;

   cddu_pkg::rsp_payload_type expected_dates [$];
   pinned_type                pinned_dates [$];
   int unsigned               mismatches  = 0;
   int unsigned               quiet_cycles = 0;

   function automatic bit leap_year(int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
   endfunction

   function automatic int unsigned month_length(int unsigned y, int unsigned m);
      case (m)
         4, 6, 9, 11: return 30;
         2:           return leap_year(y) ? 29 : 28;
         default:     return 31;
      endcase
   endfunction

   function automatic void trim_day();
      if (cal_day > month_length(cal_year, cal_month)) begin
         cal_day = month_length(cal_year, cal_month);
      end
   endfunction

   function automatic void pin_to_floor();
      cal_year  = 0;
      cal_month = cddu_pkg::MONTH_JAN;
      cal_day   = cddu_pkg::DAY_FIRST;
   endfunction

   function automatic cddu_pkg::rsp_payload_type apply_date_op(
         cddu_pkg::req_payload_type op);
      cddu_pkg::rsp_payload_type res;
      int unsigned               amt;
      bit                        uf;
      amt = op.amount;
      uf  = 1'b0;
      case (op.action)
         cddu_pkg::ACT_LOAD: begin
            cal_year  = (op.set_year > cddu_pkg::YEAR_MAX) ?
                        cddu_pkg::YEAR_MAX : op.set_year;
            cal_month = (op.set_month == 0) ? cddu_pkg::MONTH_JAN :
                        (op.set_month > cddu_pkg::MONTH_DEC) ?
                        cddu_pkg::MONTH_DEC : op.set_month;
            cal_day   = (op.set_day == 0) ? cddu_pkg::DAY_FIRST : op.set_day;
            trim_day();
         end
         cddu_pkg::ACT_DAYS: begin
            for (int unsigned i = 0; i < amt; i++) begin
               if (cal_day > 1) begin
                  cal_day--;
               end else if (cal_month > 1) begin
                  cal_month--;
                  cal_day = month_length(cal_year, cal_month);
               end else if (cal_year > 0) begin
                  cal_year--;
                  cal_month = cddu_pkg::MONTH_DEC;
                  cal_day   = cddu_pkg::DAY_DEC_LAST;
               end else begin
                  pin_to_floor();
                  uf = 1'b1;
                  break;
               end
            end
         end
         cddu_pkg::ACT_MONTHS: begin
            // clamping happens every step, so it accumulates
            for (int unsigned i = 0; i < amt; i++) begin
               if (cal_month > 1) begin
                  cal_month--;
               end else if (cal_year > 0) begin
                  cal_year--;
                  cal_month = cddu_pkg::MONTH_DEC;
               end else begin
                  pin_to_floor();
                  uf = 1'b1;
                  break;
               end
               trim_day();
            end
         end
         default: begin
            if (amt > cal_year) begin
               pin_to_floor();
               uf = 1'b1;
            end else begin
               cal_year -= amt;
               trim_day();
            end
         end
      endcase
      res.out_year  = cddu_pkg::YEAR_W'(cal_year);
      res.out_month = cddu_pkg::MONTH_W'(cal_month);
      res.out_day   = cddu_pkg::DAY_W'(cal_day);
      res.underflow = uf;
      return res;
   endfunction

   function automatic cddu_pkg::req_payload_type random_date_op();
      cddu_pkg::req_payload_type op;
      int unsigned               pick;
      op.action    = cddu_pkg::action_type'($urandom_range(0, 3));
      op.amount    = cddu_pkg::AMOUNT_FIELD_W'($urandom_range(0, 65535));
      op.set_year  = cddu_pkg::YEAR_W'($urandom);
      op.set_month = cddu_pkg::MONTH_W'($urandom);
      op.set_day   = cddu_pkg::DAY_W'($urandom);
      pick = $urandom_range(0, 99);
      case (op.action)
         cddu_pkg::ACT_LOAD: begin
            if (pick < 70) begin
               op.set_year = cddu_pkg::YEAR_W'($urandom_range(0, 9999));
            end else if (pick < 80) begin
               op.set_year = cddu_pkg::YEAR_W'($urandom_range(0, 3));
            end else if (pick < 90) begin
               op.set_year = cddu_pkg::YEAR_W'($urandom_range(0, 99) * 100);
            end
            if ($urandom_range(0, 9) != 0) begin
               op.set_month = cddu_pkg::MONTH_W'($urandom_range(1, 12));
            end
            if ($urandom_range(0, 99) < 85) begin
               op.set_day = cddu_pkg::DAY_W'($urandom_range(1, 31));
            end
         end
         cddu_pkg::ACT_DAYS, cddu_pkg::ACT_MONTHS: begin
            // full-range counts make very long step loops, so keep them rare
            if (pick >= 13) begin
               op.amount = cddu_pkg::AMOUNT_FIELD_W'($urandom_range(0, 40));
            end else if (pick >= 1) begin
               op.amount = cddu_pkg::AMOUNT_FIELD_W'($urandom_range(0, 1500));
            end
         end
         default: begin
            if (pick >= 40) begin
               op.amount = cddu_pkg::AMOUNT_FIELD_W'($urandom_range(0, 300));
            end
         end
      endcase
      return op;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   // offer one beat; returns at the edge where it is taken
   task automatic offer_date_op(cddu_pkg::req_payload_type op, bit calm);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= op;
      do @(posedge clock); while (!req_if.ready);
   endtask

   always @(posedge clock) begin : req_watch
      pinned_type                pin;
      cddu_pkg::rsp_payload_type want;
      if (!reset && req_if.valid && req_if.ready) begin
         pin  = pinned_dates.pop_front();
         want = apply_date_op(req_if.payload);
         if (pin.known) begin
            want = pin.date;
         end
         expected_dates.push_back(want);
      end
   end

   always @(posedge clock) begin : rsp_watch
      cddu_pkg::rsp_payload_type want;
      cddu_pkg::rsp_payload_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (expected_dates.size() == 0) begin
            report_mismatch($sformatf("unexpected beat %0d-%0d-%0d uf=%0d",
               got.out_year, got.out_month, got.out_day, got.underflow));
         end else begin
            want = expected_dates.pop_front();
            if (got.out_year != want.out_year)
               report_mismatch($sformatf("year %0d, want %0d", got.out_year, want.out_year));
            if (got.out_month != want.out_month)
               report_mismatch($sformatf("month %0d, want %0d", got.out_month, want.out_month));
            if (got.out_day != want.out_day)
               report_mismatch($sformatf("day %0d, want %0d", got.out_day, want.out_day));
            if (got.underflow != want.underflow)
               report_mismatch($sformatf("underflow %0d, want %0d",
                  got.underflow, want.underflow));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // result side: random stalls, one long hold-off, one stretch always ready
   initial begin : rsp_side
      int unsigned taken;
      bit          held;
      taken = 0;
      held  = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            taken++;
         end
         if (!held && taken == 120) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            rsp_if.ready <= ((taken >= 300) && (taken < 420)) ||
                            ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   initial begin : req_side
      pinned_type                pin;
      cddu_pkg::req_payload_type op;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         op.action    = DIRECTED_ROWS[i].act;
         op.amount    = DIRECTED_ROWS[i].amount;
         op.set_year  = DIRECTED_ROWS[i].year;
         op.set_month = DIRECTED_ROWS[i].month;
         op.set_day   = DIRECTED_ROWS[i].day;
         pin.known    = DIRECTED_ROWS[i].known;
         pin.date     = DIRECTED_ROWS[i].date;
         pinned_dates.push_back(pin);
         offer_date_op(op, 1'b0);
      end

      pin.known = 1'b0;
      pin.date  = '0;
      for (int i = 0; i < RANDOM_OPS; i++) begin
         pinned_dates.push_back(pin);
         offer_date_op(random_date_op(), (i >= 250) && (i < 360));
      end
      req_if.valid <= 1'b0;

      // let the watcher queue the last beat before draining
      @(posedge clock);
      while (expected_dates.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== calendar_date_decrement_unit.f =====
src/cddu_pkg.sv
src/cddu_stream_if.sv
src/cddu_dpath.sv
src/cddu_ctrl.sv
src/calendar_date_decrement_unit.sv
test/tb_top.sv
